// ===== hdl/bcas_pkg.sv =====
// ============================================================================
// bcas_pkg: shared types and constants for the charge and ADC sequencer
// Field widths, timer widths and the event records passed between blocks.
// ============================================================================
package bcas_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIMER_BITS  = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 6;   // room for 64 samples
    localparam int CNT_BITS    = 7;                 // holds 64
    localparam int POW_BITS    = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [POW_BITS-1:0] MAX_POWER = 3'd6;

    // Charger monitor events for one tick
    typedef struct packed {
        logic charging;
        logic started;
        logic ended;
    } t_charge_evt;

    // ADC sequencer events for one tick
    typedef struct packed {
        logic ref_on;
        logic start_conv;
        logic conv_off;
        logic meas_done;
    } t_adc_evt;

    // Saturating timer advance
    function automatic logic [TIMER_BITS-1:0] timer_tick(input logic [TIMER_BITS-1:0] t);
        timer_tick = (t == {TIMER_BITS{1'b1}}) ? t : t + TIMER_BITS'(1);
    endfunction

endpackage

// ===== hdl/bcas_charge.sv =====
// ============================================================================
// bcas_charge: charger status monitor
// Polls the charger pin once per poll period and flags start and end events.
// ============================================================================
module bcas_charge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_charge_signal,
    input  logic [bcas_pkg::TIMER_BITS-1:0]  i_poll_period,
    output bcas_pkg::t_charge_evt            o_evt
);

    logic                            r_flag;
    logic [bcas_pkg::TIMER_BITS-1:0] r_timer;
    logic                            n_flag;
    logic [bcas_pkg::TIMER_BITS-1:0] n_timer;
    logic [bcas_pkg::TIMER_BITS-1:0] w_tick;

    always_comb begin
        w_tick  = bcas_pkg::timer_tick(r_timer);
        n_timer = w_tick;
        n_flag  = r_flag;
        o_evt   = '0;
        if (w_tick >= i_poll_period) begin
            n_timer = '0;
            if (i_charge_signal && !r_flag) begin
                n_flag        = 1'b1;
                o_evt.started = 1'b1;
            end else if (!i_charge_signal && r_flag) begin
                n_flag      = 1'b0;
                o_evt.ended = 1'b1;
            end
        end
        o_evt.charging = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_timer <= '0;
        end else if (i_en) begin
            r_flag  <= n_flag;
            r_timer <= n_timer;
        end
    end

endmodule

// ===== hdl/bcas_adc.sv =====
// ============================================================================
// bcas_adc: three-phase averaging ADC sequencer
// Idle wait, reference settling with a dummy conversion, then summing.
// ============================================================================
module bcas_adc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_conversion_done,
    input  logic [bcas_pkg::SAMPLE_BITS-1:0]  i_sample_value,
    input  logic [bcas_pkg::TIMER_BITS-1:0]   i_measure_period,
    input  logic [bcas_pkg::TIMER_BITS-1:0]   i_prepare_time,
    input  logic [bcas_pkg::POW_BITS-1:0]     i_average_power,
    output bcas_pkg::t_adc_evt                o_evt,
    output logic [bcas_pkg::SAMPLE_BITS-1:0]  o_average
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INIT = 2'd1;
    localparam logic [1:0] PH_MEAS = 2'd2;

    logic [1:0]                          r_phase, n_phase;
    logic [bcas_pkg::TIMER_BITS-1:0]     r_timer, n_timer;
    logic [bcas_pkg::CNT_BITS-1:0]       r_cnt, n_cnt;
    logic [bcas_pkg::SUM_BITS-1:0]       r_sum, n_sum;
    logic [bcas_pkg::SAMPLE_BITS-1:0]    r_avg, n_avg;
    logic [bcas_pkg::TIMER_BITS-1:0]     w_tick;
    logic [bcas_pkg::POW_BITS-1:0]       w_power;
    logic [bcas_pkg::CNT_BITS-1:0]       w_target;
    logic [bcas_pkg::SUM_BITS-1:0]       w_acc;
    logic [bcas_pkg::SUM_BITS-1:0]       w_shifted;

    always_comb begin
        w_power   = (i_average_power > bcas_pkg::MAX_POWER) ? bcas_pkg::MAX_POWER
                                                            : i_average_power;
        w_target  = bcas_pkg::CNT_BITS'(1) << w_power;
        w_tick    = bcas_pkg::timer_tick(r_timer);
        w_acc     = r_sum + bcas_pkg::SUM_BITS'(i_sample_value);
        w_shifted = w_acc >> w_power;

        n_phase = r_phase;
        n_timer = w_tick;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_avg   = r_avg;
        o_evt   = '0;

        case (r_phase)
            PH_INIT: begin
                // settling check only counts once the dummy conversion is done
                if (i_conversion_done && (w_tick >= i_prepare_time)) begin
                    n_timer          = '0;
                    o_evt.start_conv = 1'b1;
                    n_sum            = '0;
                    n_cnt            = '0;
                    n_phase          = PH_MEAS;
                end
            end
            PH_MEAS: begin
                if (i_conversion_done) begin
                    n_cnt = r_cnt + bcas_pkg::CNT_BITS'(1);
                    n_sum = w_acc;
                    if (n_cnt >= w_target) begin
                        o_evt.conv_off  = 1'b1;
                        o_evt.meas_done = 1'b1;
                        n_sum           = w_shifted;
                        n_avg           = w_shifted[bcas_pkg::SAMPLE_BITS-1:0];
                        n_phase         = PH_IDLE;
                        n_timer         = '0;
                    end else begin
                        o_evt.start_conv = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (w_tick >= i_measure_period) begin
                    n_timer          = '0;
                    o_evt.ref_on     = 1'b1;
                    o_evt.start_conv = 1'b1;
                    n_phase          = PH_INIT;
                end
            end
        endcase
        o_average = n_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_avg   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_avg   <= n_avg;
        end
    end

endmodule

// ===== hdl/battery_charge_and_adc_average_sequencer_unit.sv =====
// ============================================================================
// battery_charge_and_adc_average_sequencer_unit: charge monitor and ADC averager
// One input transaction is one time tick; each tick yields one result.
// ============================================================================
// Path: input register, then one pass of update logic into the result
//   register.
// Throughput: 1 transaction per cycle; both stages advance together whenever
//   the result register is empty or being taken.
// Reset: synchronous, active low; clears valids, timers, phase, flags, held
//   average and loads the default configuration.
module battery_charge_and_adc_average_sequencer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream, tdata bits from the lowest: charge_signal [0],
    // conversion_done [1], sample_value [11:2], zero fill [15:12]
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,
    // Result stream, tdata bits from the lowest: charging [0],
    // charge_started [1], charge_ended [2], reference_on [3],
    // start_conversion [4], converter_off [5], measure_done [6],
    // average_value [16:7], zero fill [23:17]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [23:0]                           m_axis_tdata,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bcas_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [bcas_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam logic [bcas_pkg::CFG_IDX_BITS-1:0] CFG_POLL_PERIOD  = 2'd0;
    localparam logic [bcas_pkg::CFG_IDX_BITS-1:0] CFG_MEAS_PERIOD  = 2'd1;
    localparam logic [bcas_pkg::CFG_IDX_BITS-1:0] CFG_PREPARE_TIME = 2'd2;
    localparam logic [bcas_pkg::CFG_IDX_BITS-1:0] CFG_AVG_POWER    = 2'd3;

    // ---- configuration registers ------------------------------------------
    logic [bcas_pkg::TIMER_BITS-1:0] r_poll_period;
    logic [bcas_pkg::TIMER_BITS-1:0] r_meas_period;
    logic [bcas_pkg::TIMER_BITS-1:0] r_prepare_time;
    logic [bcas_pkg::POW_BITS-1:0]   r_avg_power;

    // ---- pipeline registers -----------------------------------------------
    logic                               r_in_valid;
    logic                               r_in_charge;
    logic                               r_in_done;
    logic [bcas_pkg::SAMPLE_BITS-1:0]   r_in_sample;
    logic                               r_out_valid;
    bcas_pkg::t_charge_evt              r_out_charge;
    bcas_pkg::t_adc_evt                 r_out_adc;
    logic [bcas_pkg::SAMPLE_BITS-1:0]   r_out_avg;

    logic                               w_adv;      // whole pipe moves this cycle
    logic                               w_step;     // a tick is applied to the state
    bcas_pkg::t_charge_evt              w_charge;
    bcas_pkg::t_adc_evt                 w_adc;
    logic [bcas_pkg::SAMPLE_BITS-1:0]   w_avg;

    // The config channel never stalls; the user must write only while the unit is idle, unenforced here.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_period  <= bcas_pkg::TIMER_BITS'(1000);
            r_meas_period  <= bcas_pkg::TIMER_BITS'(1000);
            r_prepare_time <= bcas_pkg::TIMER_BITS'(10);
            r_avg_power    <= bcas_pkg::POW_BITS'(3);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLL_PERIOD:  r_poll_period  <= i_cfg_data;
                CFG_MEAS_PERIOD:  r_meas_period  <= i_cfg_data;
                CFG_PREPARE_TIME: r_prepare_time <= i_cfg_data;
                CFG_AVG_POWER:    r_avg_power    <= i_cfg_data[bcas_pkg::POW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Advance both stages when the result slot is free or being drained, so
    // a finished result blocks the next tick only while it is not being taken.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_step        = w_adv && r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid  <= s_axis_tvalid;
            r_out_valid <= r_in_valid;
        end
    end

    // Capture the tick fields; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_charge <= s_axis_tdata[0];
            r_in_done   <= s_axis_tdata[1];
            r_in_sample <= s_axis_tdata[bcas_pkg::SAMPLE_BITS+1:2];
        end
        if (w_step) begin
            r_out_charge <= w_charge;
            r_out_adc    <= w_adc;
            r_out_avg    <= w_avg;
        end
    end

    // ---- per-tick update logic --------------------------------------------
    bcas_charge u_charge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_step),
        .i_charge_signal (r_in_charge),
        .i_poll_period   (r_poll_period),
        .o_evt           (w_charge)
    );

    bcas_adc u_adc (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_step),
        .i_conversion_done (r_in_done),
        .i_sample_value    (r_in_sample),
        .i_measure_period  (r_meas_period),
        .i_prepare_time    (r_prepare_time),
        .i_average_power   (r_avg_power),
        .o_evt             (w_adc),
        .o_average         (w_avg)
    );

    // ---- result packing ---------------------------------------------------
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_out_avg,
                            r_out_adc.meas_done,
                            r_out_adc.conv_off,
                            r_out_adc.start_conv,
                            r_out_adc.ref_on,
                            r_out_charge.ended,
                            r_out_charge.started,
                            r_out_charge.charging};

    // ---- checks -----------------------------------------------------------
    // Start and end of charging cannot both fire on one poll.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_charge.started && r_out_charge.ended))
        else $error("charge start and end in the same tick");

    // A finished series always shuts the converter down in the same tick.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_adc.meas_done == r_out_adc.conv_off))
        else $error("measure_done without converter_off");

    // Enabling the reference always kicks off the dummy conversion.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_adc.ref_on) |-> r_out_adc.start_conv)
        else $error("reference enabled without a conversion start");

    // The reported flag must agree with a start or end event.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_charge.started || r_out_charge.ended))
            |-> (r_out_charge.charging == r_out_charge.started))
        else $error("charging flag disagrees with charge event");

    // A tick that reaches the state must land in the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed tick lost before the result register");

endmodule

// ===== verif/bcas_tb_pkg.sv =====
`timescale 1ns / 100ps
// ============================================================================
// bcas_tb_pkg: tick predictor and result scoreboard for the charge/ADC unit
// Mirrors the charger monitor and the averaging ADC sequencer tick by tick and
// checks each result transaction, field by field, against the oldest tick.
// ============================================================================
package bcas_tb_pkg;

    localparam int SMP_W = bcas_pkg::SAMPLE_BITS;
    localparam int TMR_W = bcas_pkg::TIMER_BITS;

    typedef enum logic [bcas_pkg::CFG_IDX_BITS-1:0] {
        REG_CHARGE_POLL    = 2'd0,
        REG_MEASURE_PERIOD = 2'd1,
        REG_PREPARE_TIME   = 2'd2,
        REG_AVERAGE_POWER  = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        SEQ_IDLE    = 2'd0,
        SEQ_PREPARE = 2'd1,
        SEQ_MEASURE = 2'd2
    } t_seq_phase;

    // Same layout as the result tdata, charging in bit 0
    typedef struct packed {
        logic [SMP_W-1:0] average;
        logic             meas_done;
        logic             conv_off;
        logic             start_conv;
        logic             ref_on;
        logic             ended;
        logic             started;
        logic             charging;
    } t_tick_result;

    class t_tick_scoreboard;
        logic [TMR_W-1:0]                  poll_period;
        logic [TMR_W-1:0]                  measure_period;
        logic [TMR_W-1:0]                  prepare_time;
        logic [bcas_pkg::POW_BITS-1:0]     average_power;

        logic                              charging_flag;
        logic [TMR_W-1:0]                  charge_timer;
        logic [TMR_W-1:0]                  adc_timer;
        t_seq_phase                        phase;
        logic [bcas_pkg::CNT_BITS-1:0]     sample_count;
        logic [bcas_pkg::SUM_BITS-1:0]     sum;
        logic [SMP_W-1:0]                  held_average;

        t_tick_result                      expected_ticks[$];
        int                                errors;
        int                                checked;
        int                                averages;
        int                                series_started;
        int                                charge_events;

        function new();
            errors         = 0;
            checked        = 0;
            averages       = 0;
            series_started = 0;
            charge_events  = 0;
            poll_period    = 16'd1000;
            measure_period = 16'd1000;
            prepare_time   = 16'd10;
            average_power  = 3'd3;
            charging_flag  = 1'b0;
            charge_timer   = '0;
            adc_timer      = '0;
            phase          = SEQ_IDLE;
            sample_count   = '0;
            sum            = '0;
            held_average   = '0;
        endfunction

        function void write_register(t_reg_index idx, logic [15:0] value);
            case (idx)
                REG_CHARGE_POLL:    poll_period    = value;
                REG_MEASURE_PERIOD: measure_period = value;
                REG_PREPARE_TIME:   prepare_time   = value;
                REG_AVERAGE_POWER:  average_power  = value[bcas_pkg::POW_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Saturating advance of a tick counter
        function logic [TMR_W-1:0] bump(logic [TMR_W-1:0] t);
            return (&t) ? t : t + TMR_W'(1);
        endfunction

        // Advance the model by one accepted tick and queue the result it yields
        function void note_tick(logic [15:0] tdata);
            logic                          sig;
            logic                          done;
            logic [SMP_W-1:0]              sample;
            logic [bcas_pkg::POW_BITS-1:0] power;
            t_tick_result                  r;
            sig    = tdata[0];
            done   = tdata[1];
            sample = tdata[2 +: SMP_W];
            power  = (average_power > bcas_pkg::MAX_POWER) ? bcas_pkg::MAX_POWER
                                                           : average_power;
            r = '0;

            charge_timer = bump(charge_timer);
            adc_timer    = bump(adc_timer);

            if (charge_timer >= poll_period) begin
                charge_timer = '0;
                if (sig && !charging_flag) begin
                    charging_flag = 1'b1;
                    r.started     = 1'b1;
                end else if (!sig && charging_flag) begin
                    charging_flag = 1'b0;
                    r.ended       = 1'b1;
                end
            end

            case (phase)
                SEQ_PREPARE: begin
                    // settling time is only checked once the dummy conversion is done
                    if (done && adc_timer >= prepare_time) begin
                        adc_timer    = '0;
                        r.start_conv = 1'b1;
                        sum          = '0;
                        sample_count = '0;
                        phase        = SEQ_MEASURE;
                    end
                end
                SEQ_MEASURE: begin
                    if (done) begin
                        sample_count = sample_count + bcas_pkg::CNT_BITS'(1);
                        sum          = sum + bcas_pkg::SUM_BITS'(sample);
                        if (sample_count >= (7'd1 << power)) begin
                            sum          = sum >> power;
                            held_average = sum[SMP_W-1:0];
                            r.conv_off   = 1'b1;
                            r.meas_done  = 1'b1;
                            phase        = SEQ_IDLE;
                            adc_timer    = '0;
                        end else begin
                            r.start_conv = 1'b1;
                        end
                    end
                end
                default: begin
                    phase = SEQ_IDLE;
                    if (adc_timer >= measure_period) begin
                        adc_timer    = '0;
                        r.ref_on     = 1'b1;
                        r.start_conv = 1'b1;
                        phase        = SEQ_PREPARE;
                    end
                end
            endcase

            r.charging = charging_flag;
            r.average  = held_average;
            if (r.meas_done)            averages++;
            if (r.ref_on)               series_started++;
            if (r.started || r.ended)   charge_events++;
            expected_ticks.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] tdata);
            t_tick_result got;
            t_tick_result want;
            got = tdata[16:0];
            if (expected_ticks.size() == 0) begin
                $error("result 0x%06h arrived with no tick outstanding", tdata);
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            checked++;
            compare("charging",         want.charging,   got.charging);
            compare("charge_started",   want.started,    got.started);
            compare("charge_ended",     want.ended,      got.ended);
            compare("reference_on",     want.ref_on,     got.ref_on);
            compare("start_conversion", want.start_conv, got.start_conv);
            compare("converter_off",    want.conv_off,   got.conv_off);
            compare("measure_done",     want.meas_done,  got.meas_done);
            compare("average_value",    want.average,    got.average);
        endfunction
    endclass

endpackage

// ===== verif/battery_charge_and_adc_average_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// battery_charge_and_adc_average_sequencer_unit_tb: self-checking bench
// Drives ticks into the charge monitor / ADC averager under several register
// settings, with bursty input and a stalling result side, and checks every
// result transaction against a tick-accurate model of the unit.
// ============================================================================
module battery_charge_and_adc_average_sequencer_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES   = 4;     // two-stage pipe plus margin

    typedef enum logic [1:0] {
        RX_STEADY = 2'd0,
        RX_RANDOM = 2'd1,
        RX_BURSTY = 2'd2
    } t_rx_mode;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;  // charge_signal [0], conversion_done [1],
                                       // sample_value [11:2], zero fill [15:12]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [23:0] m_axis_tdata;         // charging [0], charge_started [1],
                                       // charge_ended [2], reference_on [3],
                                       // start_conversion [4], converter_off [5],
                                       // measure_done [6], average_value [16:7]
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [bcas_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [bcas_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    bcas_tb_pkg::t_tick_scoreboard sb = new();

    int       burst_left     = 0;
    bit       allow_gaps     = 1'b1;
    logic     charge_level   = 1'b0;
    int       settings_used  = 0;
    int       idle_cycles    = 0;
    t_rx_mode rx_mode        = RX_STEADY;
    int       rx_mode_left   = 0;
    int       rx_hold        = 0;
    logic     rx_level       = 1'b1;

    battery_charge_and_adc_average_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge. Register writes go
    // first so that a tick accepted later always sees the new setting.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(bcas_tb_pkg::t_reg_index'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_tick(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which no transaction of any kind happens.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: switch at random between always ready, random
    // ready and long on/off stretches.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
        end
        rx_mode_left = rx_mode_left - 1;
        case (rx_mode)
            RX_STEADY: rx_level = 1'b1;
            RX_RANDOM: rx_level = ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_hold == 0) begin
                    rx_level = ~rx_level;
                    rx_hold  = $urandom_range(1, 12);
                end
                rx_hold = rx_hold - 1;
            end
        endcase
        m_axis_tready <= rx_level;
    end

    // Write one register; hold valid until the channel takes it
    task automatic cfg_write(input bcas_tb_pkg::t_reg_index idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued result is back, then let the pipe settle
    task automatic wait_quiet();
        while (sb.expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input int poll, input int meas, input int prep,
                                  input int power);
        wait_quiet();
        cfg_write(bcas_tb_pkg::REG_CHARGE_POLL,    16'(poll));
        cfg_write(bcas_tb_pkg::REG_MEASURE_PERIOD, 16'(meas));
        cfg_write(bcas_tb_pkg::REG_PREPARE_TIME,   16'(prep));
        cfg_write(bcas_tb_pkg::REG_AVERAGE_POWER,  16'(power));
        settings_used++;
    endtask

    // Send one tick. The sender runs in bursts; a burst boundary may drop
    // valid for a random gap before the next tick goes out.
    task automatic send_tick(input logic sig, input logic done,
                             input logic [9:0] sample);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = allow_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left    = burst_left - 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, sample, done, sig};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid so the input side is idle before register writes
    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left    = 0;
    endtask

    // Random ticks: the charger line changes slowly so polls see both edges,
    // done is high at the given percentage so series complete, samples sometimes pinned to
    // their extremes.
    task automatic run_random(input int count, input int done_pct, input bit gaps);
        logic       done;
        logic [9:0] sample;
        allow_gaps = gaps;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) charge_level = ~charge_level;
            done = ($urandom_range(0, 99) < done_pct);
            case ($urandom_range(0, 7))
                0:       sample = 10'd0;
                1:       sample = 10'd1023;
                default: sample = 10'($urandom_range(0, 1023));
            endcase
            send_tick(charge_level, done, sample);
        end
        end_burst();
        allow_gaps = 1'b1;
    endtask

    initial begin
        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: long periods, so only the held flags show
        send_tick(1'b1, 1'b1, 10'd1023);
        send_tick(1'b0, 1'b0, 10'd0);
        send_tick(1'b1, 1'b0, 10'h155);
        end_burst();

        // Tightest periods, single-conversion average: every event fires fast
        apply_settings(1, 1, 0, 0);
        send_tick(1'b1, 1'b0, 10'd0);     // charge start, series start
        send_tick(1'b1, 1'b1, 10'd0);     // dummy conversion done
        send_tick(1'b0, 1'b1, 10'd1023);  // charge end, average of max sample
        send_tick(1'b0, 1'b1, 10'd0);     // done while idle is ignored
        send_tick(1'b1, 1'b1, 10'd5);
        send_tick(1'b1, 1'b0, 10'h2AA);   // wait inside the series
        send_tick(1'b1, 1'b1, 10'd0);     // average of zero
        send_tick(1'b0, 1'b1, 10'h155);
        send_tick(1'b0, 1'b1, 10'h2AA);
        end_burst();

        // Two-sample average with settling time
        apply_settings(2, 1, 2, 1);
        for (int i = 0; i < 8; i++)
            send_tick(i[1], 1'b1, (i < 4) ? 10'd1023 : 10'h155);
        end_burst();

        // Random phases, with zero periods, the power clamp and the extremes
        apply_settings(0, 0, 0, 0);
        run_random(80, 50, 1'b1);
        apply_settings(3, 5, 2, 1);
        run_random(100, 75, 1'b1);
        apply_settings(7, 2, 4, 2);
        run_random(100, 70, 1'b0);
        apply_settings(1, 10, 0, 6);
        run_random(180, 85, 1'b1);
        apply_settings(2, 1, 3, 7);
        run_random(180, 80, 1'b1);
        apply_settings(65535, 65535, 65535, 3);
        run_random(30, 60, 1'b1);
        apply_settings(5, 3, 1, 3);
        run_random(80, 75, 1'b1);

        wait_quiet();
        $display("Checked %0d ticks over %0d register settings:", sb.checked,
                 settings_used);
        $display("  %0d series started, %0d averages, %0d charge events.",
                 sb.series_started, sb.averages, sb.charge_events);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bcas_pkg.sv
hdl/bcas_charge.sv
hdl/bcas_adc.sv
hdl/battery_charge_and_adc_average_sequencer_unit.sv
verif/bcas_tb_pkg.sv
verif/battery_charge_and_adc_average_sequencer_unit_tb.sv
